>>> rtl/core/i2c_neighbor_discovery_table_defines.svh
// Assertion macros shared by the neighbor discovery table RTL.
`ifndef I2C_NEIGHBOR_DISCOVERY_TABLE_DEFINES_SVH
`define I2C_NEIGHBOR_DISCOVERY_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/ndt_pkg.sv
// Types and constants of the neighbor discovery table.
package ndt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int NODE_W     = 16;
    localparam int BUS_W      = 8;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
    localparam logic [OP_W-1:0] OP_TIMEOUT   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND_DONE = 3'd2;
    localparam logic [OP_W-1:0] OP_DISC_RX   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] MS_INIT     = 2'd0;
    localparam logic [1:0] MS_IDLE     = 2'd1;
    localparam logic [1:0] MS_DISCOVER = 2'd2;
    localparam logic [1:0] MS_ERROR    = 2'd3;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_ONESHOT = 2'd1;
    localparam logic [1:0] TMR_REPEAT  = 2'd2;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    localparam logic MODE_ACTIVE  = 1'b0;
    localparam logic MODE_PASSIVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST = 8'd1;

    localparam logic [1:0] TC_CLEAR  = 2'd0;
    localparam logic [1:0] TC_INSERT = 2'd1;
    localparam logic [1:0] TC_LOOKUP = 2'd2;
    localparam logic [1:0] TC_REMOVE = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [NODE_W-1:0] node;
        logic [BUS_W-1:0]  bus;
    } t_tbl_cmd;

    typedef struct packed {
        logic done;
        logic found;
        logic hit;
        logic full;
    } t_tbl_res;

    typedef struct packed {
        logic [1:0]       status;
        logic             send_valid;
        logic [BUS_W-1:0] send_dest;
        logic             send_kind;
        logic [1:0]       timer_start;
        logic [1:0]       mgr_state;
    } t_result;

endpackage

>>> rtl/core/ndt_if.sv
// Request, result and configuration channel interfaces.
interface ndt_in_if;
    import ndt_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [NODE_W-1:0] net_addr;
    logic [BUS_W-1:0]  bus_addr;
    logic              is_request;
    modport source (output valid, operation, net_addr, bus_addr, is_request, input ready);
    modport sink   (input valid, operation, net_addr, bus_addr, is_request, output ready);
endinterface

interface ndt_out_if;
    import ndt_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             send_valid;
    logic [BUS_W-1:0] send_dest;
    logic             send_kind;
    logic [1:0]       timer_start;
    logic [1:0]       mgr_state;
    modport source (output valid, status, send_valid, send_dest, send_kind, timer_start,
                    mgr_state, input ready);
    modport sink   (input valid, status, send_valid, send_dest, send_kind, timer_start,
                    mgr_state, output ready);
endinterface

interface ndt_cfg_if;
    import ndt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ndt_table.sv
// Neighbor table: entry memory, valid bits and the scan sequencer.
`include "i2c_neighbor_discovery_table_defines.svh"
module ndt_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ndt_pkg::t_tbl_cmd i_cmd,
    output ndt_pkg::t_tbl_res o_res
);
    import ndt_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_SCAN = 2'd1;
    localparam logic [1:0] T_FIN  = 2'd2;

    logic [NODE_W+BUS_W-1:0] r_mem [TABLE_DEPTH];
    logic [NODE_W+BUS_W-1:0] r_rd_data;

    logic [1:0]             r_state, n_state;
    logic [1:0]             r_kind, n_kind;
    logic [NODE_W-1:0]      r_node, n_node;
    logic [BUS_W-1:0]       r_bus, n_bus;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_cmp_act, n_cmp_act;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic [TABLE_DEPTH-1:0] r_vld, n_vld;
    logic                   r_found, n_found;
    logic                   r_hit, n_hit;
    logic                   r_free_ok, n_free_ok;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;

    logic w_rd_en;
    logic w_mem_we;
    logic w_done;
    logic w_cmp_v;
    logic w_node_eq;
    logic w_bus_eq;

    assign w_cmp_v   = r_vld[r_cmp_idx];
    assign w_node_eq = (r_rd_data[NODE_W+BUS_W-1:BUS_W] == r_node);
    assign w_bus_eq  = (r_rd_data[BUS_W-1:0] == r_bus);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_node     = r_node;
        n_bus      = r_bus;
        n_cnt      = r_cnt;
        n_cmp_act  = r_cmp_act;
        n_cmp_idx  = r_cmp_idx;
        n_vld      = r_vld;
        n_found    = r_found;
        n_hit      = r_hit;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        w_rd_en    = 1'b0;
        w_mem_we   = 1'b0;
        w_done     = 1'b0;

        if (r_cmp_act) begin
            if (w_cmp_v && w_node_eq) begin
                n_found = 1'b1;
            end
            if (!w_cmp_v && !r_free_ok) begin
                n_free_ok  = 1'b1;
                n_free_idx = r_cmp_idx;
            end
            if (r_kind == TC_REMOVE && w_cmp_v && (w_node_eq || w_bus_eq)) begin
                n_vld[r_cmp_idx] = 1'b0;
                n_hit            = 1'b1;
            end
        end

        case (r_state)
            T_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.kind == TC_CLEAR) begin
                        n_vld = '0;
                    end else begin
                        n_state    = T_SCAN;
                        n_kind     = i_cmd.kind;
                        n_node     = i_cmd.node;
                        n_bus      = i_cmd.bus;
                        n_cnt      = '0;
                        n_found    = 1'b0;
                        n_hit      = 1'b0;
                        n_free_ok  = 1'b0;
                        n_free_idx = '0;
                    end
                end
            end
            T_SCAN: begin
                if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    w_rd_en   = 1'b1;
                    n_cmp_act = 1'b1;
                    n_cmp_idx = r_cnt[IDX_W-1:0];
                    n_cnt     = r_cnt + CNT_W'(1);
                end else begin
                    n_cmp_act = 1'b0;
                    n_state   = T_FIN;
                end
            end
            T_FIN: begin
                w_done = 1'b1;
                if (r_kind == TC_INSERT && !r_found && r_free_ok) begin
                    w_mem_we          = 1'b1;
                    n_vld[r_free_idx] = 1'b1;
                end
                n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_free_idx] <= {r_node, r_bus};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_kind    <= TC_LOOKUP;
            r_cnt     <= '0;
            r_cmp_act <= 1'b0;
            r_vld     <= '0;
            r_found   <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_cnt     <= n_cnt;
            r_cmp_act <= n_cmp_act;
            r_vld     <= n_vld;
            r_found   <= n_found;
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_bus      <= n_bus;
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
    end

    assign o_res.done  = w_done;
    assign o_res.found = r_found;
    assign o_res.hit   = r_hit;
    assign o_res.full  = !r_found && !r_free_ok;

    `ASSERT_IMP(a_cmd_when_idle, i_clk, i_rst_n, i_cmd.valid, r_state == T_IDLE, "table command while busy")
    `ASSERT_IMP(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_act, r_state == T_SCAN, "compare outside scan")
    `ASSERT_NXT(a_scan_keeps_vld, i_clk, i_rst_n, r_state == T_SCAN && r_kind != TC_REMOVE, r_vld == $past(r_vld), "valid bits changed by non-remove scan")

endmodule

>>> rtl/core/ndt_ctrl.sv
// Discovery controller: request intake, state update and result register.
`include "i2c_neighbor_discovery_table_defines.svh"
module ndt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_mode,
    input  logic [ndt_pkg::BUS_W-1:0]  i_bcast,
    ndt_in_if.sink                     i_in,
    ndt_out_if.source                  o_out,
    output ndt_pkg::t_tbl_cmd          o_cmd,
    input  ndt_pkg::t_tbl_res          i_tres
);
    import ndt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [OP_W-1:0]  r_op;
    logic [BUS_W-1:0] r_bus;
    logic             r_req;
    logic [1:0]       r_mgr, n_mgr;
    t_result          r_res, n_res;
    logic             r_out_vld, n_out_vld;
    t_result          r_out;

    logic w_accept;
    logic w_tbl_op;
    logic w_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_tbl_op   = (r_op == OP_DISC_RX) || (r_op == OP_LOOKUP) || (r_op == OP_REMOVE);
    assign w_load     = (r_state == S_RES) && (!r_out_vld || o_out.ready);

    always_comb begin
        o_cmd.valid = 1'b0;
        o_cmd.kind  = TC_LOOKUP;
        o_cmd.node  = i_in.net_addr;
        o_cmd.bus   = i_in.bus_addr;
        case (i_in.operation)
            OP_INIT: begin
                o_cmd.valid = w_accept;
                o_cmd.kind  = TC_CLEAR;
            end
            OP_DISC_RX: begin
                o_cmd.valid = w_accept;
                o_cmd.kind  = TC_INSERT;
            end
            OP_LOOKUP: begin
                o_cmd.valid = w_accept;
                o_cmd.kind  = TC_LOOKUP;
            end
            OP_REMOVE: begin
                o_cmd.valid = w_accept;
                o_cmd.kind  = TC_REMOVE;
            end
            default: begin
                o_cmd.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_res             = '0;
        n_mgr             = r_mgr;
        n_res.status      = STAT_OK;
        n_res.send_kind   = KIND_REQUEST;
        n_res.timer_start = TMR_NONE;
        case (r_op)
            OP_INIT: begin
                n_mgr = MS_INIT;
                if (i_mode == MODE_ACTIVE) begin
                    n_res.timer_start = TMR_ONESHOT;
                end
            end
            OP_TIMEOUT: begin
                if (r_mgr == MS_INIT || r_mgr == MS_IDLE) begin
                    if (r_mgr == MS_INIT) begin
                        n_res.timer_start = TMR_REPEAT;
                    end
                    n_res.send_valid = 1'b1;
                    n_res.send_dest  = i_bcast;
                    n_res.send_kind  = KIND_REQUEST;
                    n_mgr            = MS_DISCOVER;
                end else if (r_mgr == MS_DISCOVER) begin
                    n_mgr = MS_IDLE;
                end
            end
            OP_SEND_DONE: begin
                n_mgr = MS_IDLE;
            end
            OP_DISC_RX: begin
                if (i_tres.full) begin
                    n_res.status = STAT_FULL;
                end
                if (i_mode == MODE_PASSIVE && r_req) begin
                    n_res.send_valid = 1'b1;
                    n_res.send_dest  = r_bus;
                    n_res.send_kind  = KIND_REPLY;
                    n_mgr            = MS_DISCOVER;
                end
            end
            OP_LOOKUP: begin
                n_res.status = i_tres.found ? STAT_OK : STAT_NOT_FOUND;
            end
            OP_REMOVE: begin
                n_res.status = i_tres.hit ? STAT_OK : STAT_NOT_FOUND;
            end
            default: begin
                n_mgr = r_mgr;
            end
        endcase
        n_res.mgr_state = n_mgr;
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!w_tbl_op || i_tres.done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mgr     <= MS_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (r_state == S_WAIT && (!w_tbl_op || i_tres.done)) begin
                r_mgr <= n_mgr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.operation;
            r_bus <= i_in.bus_addr;
            r_req <= i_in.is_request;
        end
        if (r_state == S_WAIT && (!w_tbl_op || i_tres.done)) begin
            r_res <= n_res;
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.send_valid  = r_out.send_valid;
    assign o_out.send_dest   = r_out.send_dest;
    assign o_out.send_kind   = r_out.send_kind;
    assign o_out.timer_start = r_out.timer_start;
    assign o_out.mgr_state   = r_out.mgr_state;

    `ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_tres.done, r_state == S_WAIT,
                "table done while not waiting")
    `ASSERT_IMP(a_quiet_send, i_clk, i_rst_n, r_state == S_RES && !r_res.send_valid,
                r_res.send_dest == '0 && r_res.send_kind == KIND_REQUEST,
                "send fields set without send")
    `ASSERT_NXT(a_hold_result, i_clk, i_rst_n, r_state == S_RES && r_out_vld && !o_out.ready,
                r_state == S_RES, "result dropped while output stalled")

endmodule

>>> rtl/core/i2c_neighbor_discovery_table.sv
// Table events (discovery received, lookup, remove) give their result after one pass over
// the entry memory, one read per cycle; other events skip the pass. One event is in work at
// a time: a new event is accepted only once the last result is loaded into the output register.
// The next event is accepted while the previous result waits in the output register.
// Reset is synchronous, active low: valid bits cleared, controller in init, mode and
// broadcast registers zero.
module i2c_neighbor_discovery_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ndt_in_if.sink    i_in,
    ndt_out_if.source o_out,
    ndt_cfg_if.sink   i_cfg
);
    import ndt_pkg::*;

    logic             r_mode;
    logic [BUS_W-1:0] r_bcast;
    t_tbl_cmd         w_cmd;
    t_tbl_res         w_tres;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ACTIVE;
            r_bcast <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_MODE) begin
                r_mode <= i_cfg.data[0];
            end else if (i_cfg.index == REG_BCAST) begin
                r_bcast <= i_cfg.data[BUS_W-1:0];
            end
        end
    end

    ndt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_bcast (r_bcast),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_cmd   (w_cmd),
        .i_tres  (w_tres)
    );

    ndt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_res   (w_tres)
    );

endmodule

>>> tb/sv/tb_i2c_neighbor_discovery_table.sv
// Self-checking testbench for the I2C neighbor discovery table: directed and random events.
module tb_i2c_neighbor_discovery_table;
    timeunit 1ns;
    timeprecision 1ps;

    import ndt_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0]      OP_SPARE7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
    localparam int                   POOL_SIZE = 24;
    localparam int                   CYCLE_LIMIT = 500000;

    class neighbor_table_scoreboard;
        bit                slot_used [TABLE_DEPTH];
        logic [NODE_W-1:0] slot_node [TABLE_DEPTH];
        logic [BUS_W-1:0]  slot_bus  [TABLE_DEPTH];
        logic [1:0]        ctrl       = MS_INIT;
        logic              mode       = MODE_ACTIVE;
        logic [BUS_W-1:0]  bcast_addr = '0;
        t_result           pending_results [$];
        int                errors;
        int                checked;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MODE)
                mode = data[0];
            else if (idx == REG_BCAST)
                bcast_addr = data;
        endfunction

        function bit holds_node(logic [NODE_W-1:0] node);
            foreach (slot_used[k])
                if (slot_used[k] && slot_node[k] == node)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_event(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                                 logic [BUS_W-1:0] bus, logic req);
            t_result r;
            int      free_slot;
            bit      hit;
            r = '0;
            r.status      = STAT_OK;
            r.send_kind   = KIND_REQUEST;
            r.timer_start = TMR_NONE;
            case (op)
                OP_INIT: begin
                    foreach (slot_used[k])
                        slot_used[k] = 1'b0;
                    ctrl = MS_INIT;
                    if (mode == MODE_ACTIVE)
                        r.timer_start = TMR_ONESHOT;
                end
                OP_TIMEOUT: begin
                    if (ctrl == MS_INIT || ctrl == MS_IDLE) begin
                        if (ctrl == MS_INIT)
                            r.timer_start = TMR_REPEAT;
                        r.send_valid = 1'b1;
                        r.send_dest  = bcast_addr;
                        r.send_kind  = KIND_REQUEST;
                        ctrl         = MS_DISCOVER;
                    end else if (ctrl == MS_DISCOVER) begin
                        ctrl = MS_IDLE;
                    end
                end
                OP_SEND_DONE: begin
                    ctrl = MS_IDLE;
                end
                OP_DISC_RX: begin
                    if (!holds_node(node)) begin
                        free_slot = -1;
                        for (int k = 0; k < TABLE_DEPTH; k++)
                            if (!slot_used[k] && free_slot < 0)
                                free_slot = k;
                        if (free_slot < 0) begin
                            r.status = STAT_FULL;
                        end else begin
                            slot_used[free_slot] = 1'b1;
                            slot_node[free_slot] = node;
                            slot_bus[free_slot]  = bus;
                        end
                    end
                    if (mode == MODE_PASSIVE && req) begin
                        r.send_valid = 1'b1;
                        r.send_dest  = bus;
                        r.send_kind  = KIND_REPLY;
                        ctrl         = MS_DISCOVER;
                    end
                end
                OP_LOOKUP: begin
                    r.status = holds_node(node) ? STAT_OK : STAT_NOT_FOUND;
                end
                OP_REMOVE: begin
                    hit = 1'b0;
                    foreach (slot_used[k])
                        if (slot_used[k] && (slot_node[k] == node || slot_bus[k] == bus)) begin
                            slot_used[k] = 1'b0;
                            hit = 1'b1;
                        end
                    r.status = hit ? STAT_OK : STAT_NOT_FOUND;
                end
                default: begin
                end
            endcase
            r.mgr_state = ctrl;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [BUS_W-1:0] want, logic [BUS_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            check_field("status", want.status, got.status);
            check_field("send_valid", want.send_valid, got.send_valid);
            check_field("send_dest", want.send_dest, got.send_dest);
            check_field("send_kind", want.send_kind, got.send_kind);
            check_field("timer_start", want.timer_start, got.timer_start);
            check_field("mgr_state", want.mgr_state, got.mgr_state);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   cycles;

    neighbor_table_scoreboard sb;
    t_result                  seen;
    logic [NODE_W-1:0]        node_pool [POOL_SIZE];
    logic [BUS_W-1:0]         bus_pool  [POOL_SIZE];

    ndt_in_if  in_ch ();
    ndt_out_if out_ch ();
    ndt_cfg_if cfg_ch ();

    i2c_neighbor_discovery_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.status      = out_ch.status;
            seen.send_valid  = out_ch.send_valid;
            seen.send_dest   = out_ch.send_dest;
            seen.send_kind   = out_ch.send_kind;
            seen.timer_start = out_ch.timer_start;
            seen.mgr_state   = out_ch.mgr_state;
            sb.check_result(seen);
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        bit          long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!long_hold_done && sb.checked >= 100) begin
                long_hold_done = 1'b1;
                stall_left     = 300;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_event(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                              input logic [BUS_W-1:0] bus, input logic req);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.net_addr   <= node;
        in_ch.bus_addr   <= bus;
        in_ch.is_request <= req;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_event(op, node, bus, req);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [BUS_W-1:0] bcast);
        cfg_write(REG_MODE, {7'd0, mode});
        cfg_write(REG_BCAST, bcast);
    endtask

    // drop valid and wait for every outstanding request to return
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int unsigned       pick;
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] node;
        logic [BUS_W-1:0]  bus;
        foreach (node_pool[k]) begin
            node_pool[k] = $urandom;
            bus_pool[k]  = $urandom;
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                op = OP_INIT;
            else if (pick < 11)
                op = OP_TIMEOUT;
            else if (pick < 18)
                op = OP_SEND_DONE;
            else if (pick < 65)
                op = OP_DISC_RX;
            else if (pick < 80)
                op = OP_LOOKUP;
            else if (pick < 91)
                op = OP_REMOVE;
            else if (pick < 93)
                op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            else
                op = OP_DISC_RX;
            node = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                              : node_pool[$urandom_range(0, POOL_SIZE - 1)];
            bus  = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                              : bus_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_event(op, node, bus, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        sb = new;
        quiet = 1'b0;
        cycles = 0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_INIT;
        in_ch.net_addr   <= '0;
        in_ch.bus_addr   <= '0;
        in_ch.is_request <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_MODE;
        cfg_ch.data      <= '0;
        rst_n            <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        configure(MODE_ACTIVE, 8'h00);
        send_event(OP_TIMEOUT,   16'h0000, 8'h00, 1'b0);
        send_event(OP_TIMEOUT,   16'h0000, 8'h00, 1'b0);
        send_event(OP_TIMEOUT,   16'h0000, 8'h00, 1'b0);
        send_event(OP_SEND_DONE, 16'h0000, 8'h00, 1'b0);
        send_event(OP_INIT,      16'h0000, 8'h00, 1'b0);
        send_event(OP_DISC_RX,   16'h0000, 8'h00, 1'b0);
        send_event(OP_DISC_RX,   16'hFFFF, 8'hFF, 1'b1);
        send_event(OP_DISC_RX,   16'hFFFF, 8'h12, 1'b0);
        send_event(OP_DISC_RX,   16'h1234, 8'h56, 1'b1);
        send_event(OP_LOOKUP,    16'hFFFF, 8'h00, 1'b0);
        send_event(OP_LOOKUP,    16'h0000, 8'hFF, 1'b1);
        send_event(OP_LOOKUP,    16'h5555, 8'h00, 1'b0);
        send_event(OP_REMOVE,    16'h0000, 8'hAA, 1'b0);
        send_event(OP_REMOVE,    16'h7777, 8'h56, 1'b0);
        send_event(OP_REMOVE,    16'h4321, 8'h77, 1'b0);
        send_event(OP_SPARE6,    16'hFFFF, 8'hFF, 1'b1);
        send_event(OP_SPARE7,    16'h0000, 8'h00, 1'b0);
        send_event(OP_LOOKUP,    16'h1234, 8'h00, 1'b0);
        send_event(OP_REMOVE,    16'hFFFF, 8'hFF, 1'b1);
        send_event(OP_TIMEOUT,   16'h0000, 8'h00, 1'b0);
        send_event(OP_INIT,      16'hFFFF, 8'hFF, 1'b1);
        run_random(230);
        settle();

        cfg_write(REG_SPARE, 8'($urandom));
        configure(MODE_PASSIVE, 8'hFF);
        send_event(OP_DISC_RX,   16'h0001, 8'hA5, 1'b1);
        send_event(OP_DISC_RX,   16'h0002, 8'h5A, 1'b0);
        send_event(OP_TIMEOUT,   16'h0000, 8'h00, 1'b0);
        send_event(OP_SEND_DONE, 16'h0000, 8'h00, 1'b0);
        send_event(OP_INIT,      16'h0000, 8'h00, 1'b0);
        run_random(230);
        settle();

        configure(MODE_ACTIVE, 8'($urandom_range(1, 254)));
        run_random(230);
        settle();

        configure(MODE_PASSIVE, 8'($urandom));
        run_random(230);
        settle();

        quiet = 1'b1;
        configure(1'($urandom_range(0, 1)), 8'($urandom));
        run_random(200);
        settle();

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ndt_pkg.sv
rtl/core/ndt_if.sv
rtl/core/ndt_table.sv
rtl/core/ndt_ctrl.sv
rtl/core/i2c_neighbor_discovery_table.sv
tb/sv/tb_i2c_neighbor_discovery_table.sv
